>>> design/stu_pkg.sv
// ----------------------------------------------------------------------------
// stu_pkg
// Shared types and constants for the STDP synapse trace update block.
// ----------------------------------------------------------------------------
package stu_pkg;

	// default sizes
	localparam int SYNAPSE_COUNT_DEF   = 1024;
	localparam int EXP_TABLE_DEPTH_DEF = 1024;

	// field widths
	localparam int SYN_W   = 10;
	localparam int TIME_W  = 32;
	localparam int TRACE_W = 32;
	localparam int TAU_W   = 32;

	// fixed point
	localparam logic [TRACE_W-1:0] Q16_ONE   = 32'h0001_0000;
	localparam logic [TRACE_W-1:0] TRACE_MAX = 32'hFFFF_FFFF;
	localparam int                 IDX_SHIFT = 18;           // Q.24 argument -> 1/64 steps
	localparam logic [32:0]        Q32_ONE   = 33'h1_0000_0000;

	// config register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRE_INV_TAU  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POST_INV_TAU = 2'd1;

	localparam logic [TAU_W-1:0] INV_TAU_RST = 32'd839;

	// exp(-1/64) in Q.32: truncated alternating series in Q.62, rounded
	function automatic logic [31:0] exp_step_ratio();
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] term;
		logic [63:0] sum;
		pos  = 64'h4000_0000_0000_0000;
		neg  = 64'd0;
		term = 64'h4000_0000_0000_0000;
		for (int n = 1; n <= 24; n++) begin
			term = term / 64'(64 * n);
			if ((n % 2) == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		sum = (pos - neg) + 64'h2000_0000;
		return sum[61:30];
	endfunction

	localparam logic [31:0] EXP_STEP_RATIO = exp_step_ratio();

	typedef struct packed {
		logic [SYN_W-1:0]  synapse;
		logic [TIME_W-1:0] event_time;
		logic              advance;
		logic              pre_spike;
		logic              post_spike;
	} stu_req_t;

	typedef struct packed {
		logic [TRACE_W-1:0] pre_trace;
		logic [TRACE_W-1:0] post_trace;
		logic               time_backwards;
	} stu_rsp_t;

endpackage

>>> design/stdp_synapse_trace_update.sv
// ----------------------------------------------------------------------------
// stdp_synapse_trace_update
// Per-synapse pre/post STDP traces with exponential decay and spike increment.
// ----------------------------------------------------------------------------
// Steps: store read, then with advance set the elapsed products, table
//   reads and roundings, then the spike step writes back and loads the
//   result. A new word is taken only in idle, after the last one has left
//   the spike step, which waits while the previous result is not taken; the
//   shared 33x32 multiplier is used four times per advancing word.
// Reset: a sweep clears the synapse store and builds the exp table; no word
//   is accepted meanwhile, config writes are taken at any time.
module stdp_synapse_trace_update
	import stu_pkg::*;
#(
	parameter int SYNAPSE_COUNT   = SYNAPSE_COUNT_DEF,
	parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 req_valid,
	output logic                 req_ready,
	input  stu_req_t             req,

	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output stu_rsp_t             rsp,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TAU_W-1:0]     cfg_data
);

	localparam int SYN_AW = (SYNAPSE_COUNT > 1) ? $clog2(SYNAPSE_COUNT) : 1;
	localparam int EXP_AW = $clog2(EXP_TABLE_DEPTH);
	localparam int INIT_N = (SYNAPSE_COUNT > EXP_TABLE_DEPTH) ? SYNAPSE_COUNT
		: EXP_TABLE_DEPTH;
	localparam int INIT_W = $clog2(INIT_N);
	localparam int PROD_W = 65;

	// one store word per synapse
	typedef struct packed {
		logic [TIME_W-1:0]  last_update;
		logic [TRACE_W-1:0] post_trace;
		logic [TRACE_W-1:0] pre_trace;
	} stu_entry_t;

	typedef enum logic [3:0] {
		ST_INIT,    // clear store, build exp table
		ST_IDLE,    // wait for a request word
		ST_READ,    // store word arrives; elapsed time and direction check
		ST_XPRE,    // mul: elapsed * pre_inv_tau
		ST_XPOST,   // table read for pre; mul: elapsed * post_inv_tau
		ST_TPRE,    // table read for post; mul: pre trace * factor
		ST_TPOST,   // round pre trace; mul: post trace * factor
		ST_PROUND,  // round post trace
		ST_SPIKE    // spike add, write back, load result
	} state_t;

	state_t state_q;

	// config
	logic [TAU_W-1:0] pre_inv_q;
	logic [TAU_W-1:0] post_inv_q;

	// init sweep
	logic [INIT_W-1:0] cnt_q;
	logic              ph_q;
	logic [32:0]       cur_q;

	// item working registers
	logic [SYN_AW-1:0]  syn_q;
	logic               inrange_q;
	logic [TIME_W-1:0]  time_q;
	logic               adv_q;
	logic               pre_q;
	logic               post_q;
	logic [TRACE_W-1:0] pt_q;
	logic [TRACE_W-1:0] qt_q;
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic               back_q;
	logic               ovf_pre_q;
	logic               ovf_post_q;

	// shared multiplier
	logic [32:0]       mul_a;
	logic [31:0]       mul_b;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] rnd;
	logic [31:0]       dec_val;
	logic              idx_ovf;

	// memories
	stu_entry_t        st_mem [SYNAPSE_COUNT];
	stu_entry_t        st_rd_q;
	logic              st_we;
	logic [SYN_AW-1:0] st_waddr;
	stu_entry_t        st_wdata;
	logic              st_re;

	logic [32:0]       exp_mem [EXP_TABLE_DEPTH];
	logic [32:0]       rom_q;
	logic              rom_we;
	logic              rom_re;

	// result
	logic               rsp_valid_q;
	stu_rsp_t           rsp_q;
	logic               rsp_free;
	logic [TRACE_W-1:0] pt_new;
	logic [TRACE_W-1:0] qt_new;
	logic               init_last;
	logic               req_acc;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign init_last = (cnt_q == INIT_W'(INIT_N - 1)) && ph_q;

	// rounding and table range on the registered product
	assign rnd     = prod_q + PROD_W'(33'h0_8000_0000);
	assign dec_val = rnd[63:32];
	assign idx_ovf = (prod_q[63:IDX_SHIFT] >= (64 - IDX_SHIFT)'(EXP_TABLE_DEPTH));

	// spike add, saturating
	assign pt_new = !pre_q ? pt_q : ((pt_q > (TRACE_MAX - Q16_ONE)) ? TRACE_MAX
		: pt_q + Q16_ONE);
	assign qt_new = !post_q ? qt_q : ((qt_q > (TRACE_MAX - Q16_ONE)) ? TRACE_MAX
		: qt_q + Q16_ONE);

	// multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_INIT: begin
				mul_a = cur_q;
				mul_b = EXP_STEP_RATIO;
			end
			ST_XPOST: begin
				mul_a = {1'b0, elapsed_q};
				mul_b = post_inv_q;
			end
			ST_TPRE: begin
				mul_a = rom_q;
				mul_b = pt_q;
			end
			ST_TPOST: begin
				mul_a = rom_q;
				mul_b = qt_q;
			end
			default: begin
				mul_a = {1'b0, elapsed_q};
				mul_b = pre_inv_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// synapse store: one write, one registered read
	always_comb begin
		st_we    = 1'b0;
		st_waddr = syn_q;
		st_wdata = '0;
		if (state_q == ST_INIT) begin
			st_we    = !ph_q && (32'(cnt_q) < 32'(SYNAPSE_COUNT));
			st_waddr = cnt_q[SYN_AW-1:0];
		end else if (state_q == ST_SPIKE) begin
			st_we    = inrange_q && rsp_free;
			st_wdata = '{last_update: (adv_q ? time_q : last_q),
				post_trace: qt_new, pre_trace: pt_new};
		end
	end

	assign st_re = req_acc;

	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_waddr] <= st_wdata;
		end
		if (st_re) begin
			st_rd_q <= st_mem[SYN_AW'(req.synapse)];
		end
	end

	// exp table: built at reset, read from the argument in the product
	assign rom_we = (state_q == ST_INIT) && !ph_q && (32'(cnt_q) < 32'(EXP_TABLE_DEPTH));
	assign rom_re = (state_q == ST_XPOST) || (state_q == ST_TPRE);

	always_ff @(posedge clk) begin
		if (rom_we) begin
			exp_mem[cnt_q[EXP_AW-1:0]] <= cur_q;
		end
		if (rom_re) begin
			rom_q <= exp_mem[prod_q[IDX_SHIFT +: EXP_AW]];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_inv_q  <= INV_TAU_RST;
			post_inv_q <= INV_TAU_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRE_INV_TAU:  pre_inv_q  <= cfg_data;
				CFG_POST_INV_TAU: post_inv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			ph_q        <= 1'b0;
			cur_q       <= Q32_ONE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			syn_q       <= '0;
			inrange_q   <= 1'b0;
			time_q      <= '0;
			adv_q       <= 1'b0;
			pre_q       <= 1'b0;
			post_q      <= 1'b0;
			pt_q        <= '0;
			qt_q        <= '0;
			last_q      <= '0;
			elapsed_q   <= '0;
			back_q      <= 1'b0;
			ovf_pre_q   <= 1'b0;
			ovf_post_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					// even phase writes entry and multiplies, odd phase rounds
					ph_q <= !ph_q;
					if (ph_q) begin
						cur_q <= rnd[64:32];
						cnt_q <= cnt_q + 1'b1;
					end
					if (init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						syn_q     <= SYN_AW'(req.synapse);
						inrange_q <= (32'(req.synapse) < 32'(SYNAPSE_COUNT));
						time_q    <= req.event_time;
						adv_q     <= req.advance;
						pre_q     <= req.pre_spike;
						post_q    <= req.post_spike;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					pt_q      <= st_rd_q.pre_trace;
					qt_q      <= st_rd_q.post_trace;
					last_q    <= st_rd_q.last_update;
					back_q    <= adv_q && (time_q < st_rd_q.last_update);
					elapsed_q <= (time_q < st_rd_q.last_update) ? '0
						: time_q - st_rd_q.last_update;
					state_q   <= (adv_q && inrange_q) ? ST_XPRE : ST_SPIKE;
				end
				ST_XPRE: begin
					state_q <= ST_XPOST;
				end
				ST_XPOST: begin
					ovf_pre_q <= idx_ovf;
					state_q   <= ST_TPRE;
				end
				ST_TPRE: begin
					ovf_post_q <= idx_ovf;
					state_q    <= ST_TPOST;
				end
				ST_TPOST: begin
					pt_q    <= ovf_pre_q ? '0 : dec_val;
					state_q <= ST_PROUND;
				end
				ST_PROUND: begin
					qt_q    <= ovf_post_q ? '0 : dec_val;
					state_q <= ST_SPIKE;
				end
				ST_SPIKE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						if (inrange_q) begin
							rsp_q <= '{pre_trace: pt_new, post_trace: qt_new,
								time_backwards: back_q};
						end else begin
							rsp_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a new result only comes out of the spike step
	a_rsp_from_spike: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_SPIKE))
		else $error("result loaded outside spike step");

	// an accepted word always starts with the store read
	a_acc_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (state_q == ST_READ))
		else $error("accepted word did not start a store read");

	// decay never grows the pre trace
	a_decay_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TPOST) |=> (pt_q <= $past(pt_q)))
		else $error("pre trace grew during decay");

	// the store is written only by the init sweep or the final step
	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> ((state_q == ST_INIT) || (state_q == ST_SPIKE)))
		else $error("store written outside init or spike step");

endmodule

>>> tb/sv/stdp_synapse_trace_update_test.sv
// ----------------------------------------------------------------------------
// stdp_synapse_trace_update_test
// Self-checking bench for the STDP trace update block. A bit-true predictor
// keeps its own trace and time stores and its own exp(-x) table. Every
// response word is checked against the oldest predicted word. Stimulus:
// directed corner words, then random spike traffic under several time
// constant settings, and a short burst of repeated spikes on one synapse.
// ----------------------------------------------------------------------------
module stdp_synapse_trace_update_test;
	timeunit 1ns;
	timeprecision 1ps;

	import stu_pkg::*;

	localparam int SYN_COUNT    = SYNAPSE_COUNT_DEF;
	localparam int EXP_DEPTH    = EXP_TABLE_DEPTH_DEF;
	localparam int IDLE_PCT     = 9;
	localparam int DRAIN_CYCLES = 20;     // well past the latency of an advancing word
	localparam int HOT_COUNT    = 8;

	// spikes with no advance stack both traces on one synapse
	localparam int SAT_SYNAPSE = 777;
	localparam int SAT_WORDS   = 4;

	// index 2 and 3 decode to no register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	// with the reset tau, this many ticks is the first elapsed time whose
	// table index falls off the end of the table (one less hits the last entry)
	localparam int unsigned EDGE_TICKS =
		((EXP_DEPTH << IDX_SHIFT) + INV_TAU_RST - 1) / INV_TAU_RST;

	// ------------------------------------------------------------------
	// DUT connections; every input is known from time zero
	// ------------------------------------------------------------------
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	stu_req_t             req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	stu_rsp_t             rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TAU_W-1:0]     cfg_data  = '0;

	stdp_synapse_trace_update dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	stu_req_t spike_words[$];     // request words waiting for the driver
	stu_rsp_t traces_due[$];      // predicted response words, oldest first
	logic     req_taken = 1'b0;   // request handshake seen at the last rising edge
	int       req_idle_pct  = IDLE_PCT;
	int       rsp_stall_pct = IDLE_PCT;
	int       mismatch_count = 0;

	// predictor copy of the block
	bit [32:0]          exp_neg_q32 [EXP_DEPTH];   // exp(-i/64), 1.0 = 2^32
	bit [TAU_W-1:0]     pre_tau_q24  = INV_TAU_RST;
	bit [TAU_W-1:0]     post_tau_q24 = INV_TAU_RST;
	bit [TRACE_W-1:0]   pre_trace_mem  [SYN_COUNT];
	bit [TRACE_W-1:0]   post_trace_mem [SYN_COUNT];
	bit [TIME_W-1:0]    last_tick_mem  [SYN_COUNT];

	// stimulus side: the generator's idea of each synapse's clock, used only
	// to pick sensible tick steps
	bit [TIME_W-1:0]    gen_tick [SYN_COUNT];
	int unsigned        hot_syn [HOT_COUNT];

	// exp(-1/64) from the alternating series in Q.62 (each term truncated),
	// rounded to Q.32; the table is built by repeated multiply with rounding
	initial begin : exp_table_build
		bit [63:0] pos;
		bit [63:0] neg;
		bit [63:0] term;
		bit [31:0] ratio;
		bit [95:0] prod;
		pos  = 64'h4000_0000_0000_0000;
		neg  = 64'd0;
		term = pos;
		for (int n = 1; n <= 24; n++) begin
			term = term / (64 * n);
			if (n % 2) begin
				neg += term;
			end else begin
				pos += term;
			end
		end
		ratio = 32'((pos - neg + 64'h2000_0000) >> 30);
		exp_neg_q32[0] = Q32_ONE;
		for (int i = 1; i < EXP_DEPTH; i++) begin
			prod = 96'(exp_neg_q32[i-1]) * 96'(ratio) + (96'd1 << 31);
			exp_neg_q32[i] = prod[64:32];
		end
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// trace * exp(-elapsed/tau), argument truncated to 1/64 steps;
	// an index past the table end means full decay
	function automatic bit [TRACE_W-1:0] decayed(bit [TRACE_W-1:0] trace,
			bit [TIME_W-1:0] elapsed, bit [TAU_W-1:0] inv_tau);
		bit [63:0] arg;
		bit [95:0] prod;
		arg = 64'(elapsed) * 64'(inv_tau);
		if ((arg >> IDX_SHIFT) >= EXP_DEPTH) begin
			return '0;
		end
		prod = 96'(trace) * 96'(exp_neg_q32[arg >> IDX_SHIFT]) + (96'd1 << 31);
		return prod[63:32];
	endfunction

	function automatic bit [TRACE_W-1:0] plus_one_sat(bit [TRACE_W-1:0] trace);
		return (trace > TRACE_MAX - Q16_ONE) ? TRACE_MAX : trace + Q16_ONE;
	endfunction

	// One request word -> one response word. The 10-bit synapse field cannot
	// exceed the store size, so the out-of-range path never applies here.
	function automatic stu_rsp_t trace_update(stu_req_t w);
		stu_rsp_t         r;
		bit [TRACE_W-1:0] pre_t;
		bit [TRACE_W-1:0] post_t;
		bit [TIME_W-1:0]  elapsed;
		pre_t  = pre_trace_mem[w.synapse];
		post_t = post_trace_mem[w.synapse];
		r.time_backwards = 1'b0;
		if (w.advance) begin
			// earlier tick: no decay, flag raised, tick still stored
			if (w.event_time < last_tick_mem[w.synapse]) begin
				r.time_backwards = 1'b1;
				elapsed = '0;
			end else begin
				elapsed = w.event_time - last_tick_mem[w.synapse];
			end
			pre_t  = decayed(pre_t, elapsed, pre_tau_q24);
			post_t = decayed(post_t, elapsed, post_tau_q24);
			last_tick_mem[w.synapse] = w.event_time;
		end
		if (w.pre_spike) begin
			pre_t = plus_one_sat(pre_t);
		end
		if (w.post_spike) begin
			post_t = plus_one_sat(post_t);
		end
		pre_trace_mem[w.synapse]  = pre_t;
		post_trace_mem[w.synapse] = post_t;
		r.pre_trace  = pre_t;
		r.post_trace = post_t;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: new request words and ready change on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			// a word stays put until taken; only then may the next one go up
			if (!req_valid || req_taken) begin
				if (spike_words.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
					req       <= spike_words.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= $urandom_range(99) >= rsp_stall_pct;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: all handshakes are sampled on the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		stu_rsp_t due;
		req_taken <= req_valid && req_ready;

		// check first: a word taken now cannot answer itself
		if (rsp_valid && rsp_ready) begin
			if (traces_due.size() == 0) begin
				$error("unexpected response word: %p", rsp);
				mismatch_count++;
			end else begin
				due = traces_due.pop_front();
				if (rsp.pre_trace !== due.pre_trace) begin
					$error("pre_trace: expected %h, actual %h", due.pre_trace, rsp.pre_trace);
					mismatch_count++;
				end
				if (rsp.post_trace !== due.post_trace) begin
					$error("post_trace: expected %h, actual %h",
						due.post_trace, rsp.post_trace);
					mismatch_count++;
				end
				if (rsp.time_backwards !== due.time_backwards) begin
					$error("time_backwards: expected %b, actual %b",
						due.time_backwards, rsp.time_backwards);
					mismatch_count++;
				end
			end
		end

		if (req_valid && req_ready) begin
			traces_due.push_back(trace_update(req));
		end

		// writes only happen while idle, so applying them here is in order
		if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PRE_INV_TAU) begin
				pre_tau_q24 = cfg_data;
			end else if (cfg_index == CFG_POST_INV_TAU) begin
				post_tau_q24 = cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_word(int unsigned syn, bit [TIME_W-1:0] tick,
			bit adv, bit pre, bit post);
		stu_req_t w;
		w.synapse    = SYN_W'(syn);
		w.event_time = tick;
		w.advance    = adv;
		w.pre_spike  = pre;
		w.post_spike = post;
		spike_words.push_back(w);
		if (adv) begin
			gen_tick[syn] = tick;
		end
	endtask

	// Mostly a handful of busy synapses moving forward in time, so traces
	// build up and decay; some backward ticks, some wild ticks, some cold
	// synapses anywhere in the store.
	task automatic queue_random(int count);
		int unsigned     syn;
		int unsigned     pick;
		bit [TIME_W-1:0] tick;
		for (int k = 0; k < count; k++) begin
			syn = ($urandom_range(99) < 85) ? hot_syn[$urandom_range(HOT_COUNT-1)]
				: $urandom_range(SYN_COUNT-1);
			pick = $urandom_range(99);
			if (pick < 5) begin
				tick = gen_tick[syn] - $urandom_range(1, 5000);
			end else if (pick < 10) begin
				tick = $urandom;
			end else if (pick < 45) begin
				tick = gen_tick[syn] + $urandom_range(64);
			end else if (pick < 80) begin
				tick = gen_tick[syn] + $urandom_range(4096);
			end else begin
				tick = gen_tick[syn] + $urandom_range(400000);
			end
			queue_word(syn, tick, $urandom_range(99) < 75, $urandom_range(99) < 40,
				$urandom_range(99) < 40);
		end
	endtask

	// valid stays high across back-to-back writes; retune drops it at the end
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TAU_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic retune(logic [TAU_W-1:0] pre_tau, logic [TAU_W-1:0] post_tau);
		write_reg(CFG_PRE_INV_TAU, pre_tau);
		write_reg(CFG_POST_INV_TAU, post_tau);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sender holds off until every word sent has been answered
	task automatic wait_drained();
		do @(posedge clk);
		while (spike_words.size() != 0 || req_valid || traces_due.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		hot_syn[0] = 0;
		hot_syn[1] = SYN_COUNT - 1;
		for (int i = 2; i < HOT_COUNT; i++) begin
			hot_syn[i] = $urandom_range(SYN_COUNT - 1);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words, reset time constants
		queue_word(0, 0, 1, 1, 1);                 // zero elapsed, both spikes
		queue_word(0, 100, 1, 0, 0);               // plain decay
		queue_word(0, 50, 1, 0, 0);                // earlier tick
		queue_word(0, 10, 0, 1, 0);                // no advance: no flag, no decay
		queue_word(0, 50, 1, 0, 1);                // same tick again
		queue_word(SYN_COUNT-1, 32'hFFFF_FFFF, 1, 1, 0);   // far past table end
		queue_word(SYN_COUNT-1, 32'hFFFF_FFFF, 1, 0, 1);
		queue_word(SYN_COUNT-1, 0, 1, 1, 1);       // back from the top tick
		queue_word(512, 32'h7FFF_FFFF, 0, 1, 1);
		queue_word(341, 32'h5555_5555, 1, 1, 0);   // alternating bit patterns
		queue_word(682, 32'hAAAA_AAAA, 1, 0, 1);
		queue_word(2, 1000, 1, 1, 1);
		queue_word(2, gen_tick[2] + EDGE_TICKS - 1, 1, 0, 0);   // last table entry
		queue_word(2, gen_tick[2], 0, 1, 1);
		queue_word(2, gen_tick[2] + EDGE_TICKS, 1, 0, 0);       // first index off the end
		queue_random(180);
		wait_drained();

		// one tick per table step on pre, coarser on post
		retune(32'h0004_0000, 32'h0000_4000);
		queue_random(250);
		wait_drained();

		// extremes: no decay at all vs. full decay on any elapsed tick
		retune(32'h0000_0000, 32'hFFFF_FFFF);
		queue_random(200);
		wait_drained();

		// spare indexes must not disturb either register
		write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_3, 32'h0000_0001);
		retune(32'hFFFF_FFFF, 32'h0000_0000);
		queue_random(200);
		wait_drained();

		// long stretch with no idle and no stall on either side
		req_idle_pct  = 0;
		rsp_stall_pct = 0;
		retune($urandom_range(200, 5000), $urandom_range(200, 5000));
		queue_random(250);
		wait_drained();
		req_idle_pct  = IDLE_PCT;
		rsp_stall_pct = IDLE_PCT;

		// back to reset values; stack spikes on one synapse, then decay it
		retune(INV_TAU_RST, INV_TAU_RST);
		for (int i = 0; i < SAT_WORDS; i++) begin
			queue_word(SAT_SYNAPSE, gen_tick[SAT_SYNAPSE], 0, 1, 1);
		end
		queue_word(SAT_SYNAPSE, gen_tick[SAT_SYNAPSE] + 1, 1, 0, 0);
		queue_word(SAT_SYNAPSE, gen_tick[SAT_SYNAPSE] + 3000, 1, 1, 1);
		queue_random(300);
		wait_drained();

		// let any stray response word show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// hang guard, several times the slowest legal run
	initial begin
		#40_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
design/stu_pkg.sv
design/stdp_synapse_trace_update.sv
tb/sv/stdp_synapse_trace_update_test.sv
